>>> src/ata_pkg.sv
// ata_pkg: shared constants, types and the arctangent table for the tilt angle block
// no dependencies; imported by every module of the block

package ata_pkg;

	// sample and result formats
	localparam int SAMPLE_BITS     = 12;
	localparam int ANGLE_FRAC_BITS = 13;
	localparam int ANGLE_W         = ANGLE_FRAC_BITS + 2;

	// stream word widths, padded to whole bytes
	localparam int IN_DATA_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((ANGLE_W + 7) / 8) * 8;

	// sum of squares and its square root (root carries ROOT_PAD fraction bits)
	localparam int SQ_W     = 2 * SAMPLE_BITS;
	localparam int ROOT_PAD = 16;
	localparam int ROOT_W   = SAMPLE_BITS + ROOT_PAD;
	localparam int REM_W    = ROOT_W + 3;

	// cordic datapath; x/y grow by the cordic gain, angle accumulates in Q30
	localparam int CX_W         = SAMPLE_BITS + ROOT_PAD + 3;
	localparam int CORDIC_STEPS = 30;
	localparam int ACC_W        = 32;
	localparam int ACC_FRAC     = 30;
	localparam int RND_SH       = ACC_FRAC - ANGLE_FRAC_BITS;

	localparam logic [ACC_W-1:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [ACC_W:0]   RND_HALF    = (ACC_W + 1)'(1) << (RND_SH - 1);
	localparam logic [ANGLE_W-1:0] ANGLE_LIM =
		ANGLE_W'((64'(HALF_PI_Q30) + (64'd1 << (RND_SH - 1))) >> RND_SH);

	// atan(2^-i) in Q30, truncated toward zero
	localparam logic signed [ACC_W-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
	};

	// queue between front and back (depth a power of two)
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// classification of one sample
	typedef struct packed {
		logic neg;       // numerator negative
		logic zero_den;  // denominator is zero
		logic undef;     // numerator and denominator both zero
	} ata_flags_t;

	// one classified sample as queued for the back end
	typedef struct packed {
		logic [SQ_W-1:0]        sum;    // sum of the two denominator squares
		logic [SAMPLE_BITS-1:0] mag_n;  // numerator magnitude
		ata_flags_t             flags;
	} ata_item_t;

endpackage

>>> src/ata_front.sv
// ata_front: accepts samples, selects numerator and denominator axes, squares and classifies
// depends on ata_pkg; feeds ata_fifo

module ata_front import ata_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,   // accel_x, accel_y, accel_z, zero pad
	input  logic [0:0]           s_tuser,   // opcode
	output logic                 wr_vld,
	input  logic                 wr_rdy,
	output ata_item_t            wr_item
);

	logic [SAMPLE_BITS-1:0] ax_x, ax_y, ax_z, num, den_a, num_mag;
	logic                   roll, adv;
	logic signed [2*SAMPLE_BITS-1:0] prod_a, prod_z;
	logic [SQ_W-1:0]        sum;

	logic                   vld_s1;
	logic [SQ_W-2:0]        sq_a_s1, sq_z_s1;
	logic [SAMPLE_BITS-1:0] mag_s1;
	logic                   neg_s1, nz_s1;

	logic                   vld_s2;
	ata_item_t              item_s2;

	// field unpack and axis selection
	assign ax_x  = s_tdata[0 +: SAMPLE_BITS];
	assign ax_y  = s_tdata[SAMPLE_BITS +: SAMPLE_BITS];
	assign ax_z  = s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
	assign roll  = s_tuser[0];
	assign num   = roll ? ax_y : ax_x;
	assign den_a = roll ? ax_x : ax_y;

	// squares and numerator magnitude
	assign prod_a  = $signed(den_a) * $signed(den_a);
	assign prod_z  = $signed(ax_z) * $signed(ax_z);
	assign num_mag = num[SAMPLE_BITS-1] ? (~num + 1'b1) : num;

	// both stages move together unless a finished word waits on a full queue
	assign adv      = !vld_s2 || wr_rdy;
	assign s_tready = adv;

	assign sum = {1'b0, sq_a_s1} + {1'b0, sq_z_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_a_s1 <= prod_a[2*SAMPLE_BITS-2:0];
			sq_z_s1 <= prod_z[2*SAMPLE_BITS-2:0];
			mag_s1  <= num_mag;
			neg_s1  <= num[SAMPLE_BITS-1];
			nz_s1   <= num != '0;

			item_s2.sum            <= sum;
			item_s2.mag_n          <= mag_s1;
			item_s2.flags.neg      <= neg_s1;
			item_s2.flags.zero_den <= sum == '0;
			item_s2.flags.undef    <= (sum == '0) && !nz_s1;
		end
	end

	assign wr_vld  = vld_s2;
	assign wr_item = item_s2;

	// a word held back by the queue stays put
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !wr_rdy |=> vld_s2 && $stable(item_s2))
		else $error("front stage 2 changed while the queue was full");

endmodule

>>> src/ata_fifo.sv
// ata_fifo: short flip-flop queue that decouples the front end from the back end
// depends on ata_pkg

module ata_fifo import ata_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_vld,
	output logic      wr_rdy,
	input  ata_item_t wr_item,
	output logic      rd_vld,
	input  logic      rd_rdy,
	output ata_item_t rd_item
);

	ata_item_t               mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   cnt_q;
	logic                    push, pop;

	assign wr_rdy  = cnt_q != FIFO_CNT_W'(FIFO_DEPTH);
	assign rd_vld  = cnt_q != '0;
	assign push    = wr_vld && wr_rdy;
	assign pop     = rd_vld && rd_rdy;
	assign rd_item = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("queue count beyond depth");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a write");

	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count missed a read");

endmodule

>>> src/ata_back.sv
// ata_back: pipelined square root, vectoring cordic and rounding with an output register
// depends on ata_pkg; drains ata_fifo

module ata_back import ata_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_vld,
	output logic               rd_rdy,
	input  ata_item_t          rd_item,
	output logic               out_vld,
	input  logic               out_rdy,
	output logic [ANGLE_W-1:0] out_angle,
	output logic               out_undef
);

	logic adv;

	// square root stages, one result bit each
	logic [REM_W-1:0]  rem_q    [ROOT_W];
	logic [ROOT_W-1:0] root_q   [ROOT_W];
	ata_item_t         sq_item_q [ROOT_W];
	logic              sq_vld_q [ROOT_W];

	// cordic stages
	logic signed [CX_W-1:0]  cx_q   [CORDIC_STEPS];
	logic signed [CX_W-1:0]  cy_q   [CORDIC_STEPS];
	logic signed [ACC_W-1:0] acc_q  [CORDIC_STEPS];
	ata_flags_t              c_fl_q [CORDIC_STEPS];
	logic                    c_vld_q [CORDIC_STEPS];

	// output register
	logic               out_vld_q;
	logic [ANGLE_W-1:0] out_angle_q;
	logic               out_undef_q;

	// whole back end moves while the output register is free or being taken
	assign adv    = !out_vld_q || out_rdy;
	assign rd_rdy = adv;

	// digit-by-digit root of sum * 2^(2*ROOT_PAD)
	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		localparam int P = ROOT_W - 1 - j;
		logic [REM_W-1:0]  rem_in, rem_sh, trial, rem_nx;
		logic [ROOT_W-1:0] root_in;
		logic [1:0]        pair;
		logic              ge, vld_in;
		ata_item_t         item_in;

		if (j == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign item_in = rd_item;
			assign vld_in  = rd_vld;
		end else begin : g_next
			assign rem_in  = rem_q[j-1];
			assign root_in = root_q[j-1];
			assign item_in = sq_item_q[j-1];
			assign vld_in  = sq_vld_q[j-1];
		end

		// low pairs of the scaled radicand are zero
		if (P >= ROOT_PAD) begin : g_pair
			assign pair = item_in.sum[2*(P-ROOT_PAD) +: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign rem_sh = {rem_in[REM_W-3:0], pair};
		assign trial  = {1'b0, root_in, 2'b01};
		assign ge     = rem_sh >= trial;
		assign rem_nx = ge ? (rem_sh - trial) : rem_sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_q[j] <= 1'b0;
			end else if (adv) begin
				sq_vld_q[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[j]     <= rem_nx;
				root_q[j]    <= {root_in[ROOT_W-2:0], ge};
				sq_item_q[j] <= item_in;
			end
		end
	end

	// vectoring cordic on (root, numerator), both with ROOT_PAD fraction bits
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		logic signed [CX_W-1:0]  cx_in, cy_in, dx, dy;
		logic signed [ACC_W-1:0] acc_in;
		ata_flags_t              fl_in;
		logic                    vld_in;

		if (i == 0) begin : g_first
			assign cx_in  = signed'(CX_W'(root_q[ROOT_W-1]));
			assign cy_in  = signed'(CX_W'({sq_item_q[ROOT_W-1].mag_n, {ROOT_PAD{1'b0}}}));
			assign acc_in = '0;
			assign fl_in  = sq_item_q[ROOT_W-1].flags;
			assign vld_in = sq_vld_q[ROOT_W-1];
		end else begin : g_next
			assign cx_in  = cx_q[i-1];
			assign cy_in  = cy_q[i-1];
			assign acc_in = acc_q[i-1];
			assign fl_in  = c_fl_q[i-1];
			assign vld_in = c_vld_q[i-1];
		end

		assign dx = cy_in >>> i;
		assign dy = cx_in >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_vld_q[i] <= 1'b0;
			end else if (adv) begin
				c_vld_q[i] <= vld_in;
			end
		end

		// rotate toward the x axis by the sign of y
		always_ff @(posedge clk) begin
			if (adv) begin
				c_fl_q[i] <= fl_in;
				if (!cy_in[CX_W-1]) begin
					cx_q[i]  <= cx_in + dx;
					cy_q[i]  <= cy_in - dy;
					acc_q[i] <= acc_in + ATAN_Q30[i];
				end else begin
					cx_q[i]  <= cx_in - dx;
					cy_q[i]  <= cy_in + dy;
					acc_q[i] <= acc_in - ATAN_Q30[i];
				end
			end
		end
	end

	// magnitude, round half up, limit to pi/2, apply sign
	logic [ACC_W-1:0]   mag;
	logic [ACC_W:0]     rsum;
	logic [ANGLE_W-1:0] rmag, rlim, ang;
	ata_flags_t         fl_last;

	assign fl_last = c_fl_q[CORDIC_STEPS-1];

	always_comb begin
		mag = acc_q[CORDIC_STEPS-1][ACC_W-1] ? '0 : acc_q[CORDIC_STEPS-1];
		if (fl_last.zero_den) mag = HALF_PI_Q30;
		rsum = {1'b0, mag} + RND_HALF;
		rmag = rsum[RND_SH +: ANGLE_W];
		rlim = (rmag > ANGLE_LIM) ? ANGLE_LIM : rmag;
		ang  = fl_last.neg ? (~rlim + 1'b1) : rlim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= c_vld_q[CORDIC_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_angle_q <= fl_last.undef ? '0 : ang;
			out_undef_q <= fl_last.undef;
		end
	end

	assign out_vld   = out_vld_q;
	assign out_angle = out_angle_q;
	assign out_undef = out_undef_q;

	// a stalled back end freezes its occupancy at both ends
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(sq_vld_q[0]) && $stable(c_vld_q[CORDIC_STEPS-1]))
		else $error("back end pipeline moved during a stall");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_undef_q |-> out_angle_q == '0)
		else $error("undefined result with nonzero angle");

endmodule

>>> src/accel_tilt_angle.sv
// accel_tilt_angle: pitch or roll angle from one three-axis accelerometer sample
// depends on ata_pkg, ata_front, ata_fifo, ata_back
//
// Input channel s_*: one word per sample; tdata holds accel_x, accel_y, accel_z
// (signed 12-bit counts), tuser[0] picks pitch (0, numerator x) or roll (1, numerator y).
// Output channel m_*: one word per sample; tdata holds the angle in radians, signed
// Q2.13 within +-pi/2, tuser[0] is set when all terms are zero (angle then 0).
// Throughput is one sample per clock unless stalled. On its way to m_tvalid a sample
// passes two front stages, the queue write, one square root stage per root bit
// (SAMPLE_BITS + 16 = 28), one CORDIC stage per step (30) and the rounding register.
// When a finished word waits in the output register the whole back pipeline freezes;
// the front end keeps taking samples until the four-entry queue is full and its second
// stage holds a word, and only then drops s_tready. The result waits until taken.
// Reset clears all valid bits and the queue; no sweep is needed before the first word.

module accel_tilt_angle import ata_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // accel_x, accel_y, accel_z, zero pad
	input  logic [0:0]            s_tuser,   // opcode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // tilt_angle, zero pad
	output logic [0:0]            m_tuser    // undefined_flag
);

	logic               wr_vld, wr_rdy, rd_vld, rd_rdy, out_undef;
	ata_item_t          wr_item, rd_item;
	logic [ANGLE_W-1:0] out_angle;

	ata_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.wr_vld   (wr_vld),
		.wr_rdy   (wr_rdy),
		.wr_item  (wr_item)
	);

	ata_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_vld  (wr_vld),
		.wr_rdy  (wr_rdy),
		.wr_item (wr_item),
		.rd_vld  (rd_vld),
		.rd_rdy  (rd_rdy),
		.rd_item (rd_item)
	);

	ata_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_vld    (rd_vld),
		.rd_rdy    (rd_rdy),
		.rd_item   (rd_item),
		.out_vld   (m_tvalid),
		.out_rdy   (m_tready),
		.out_angle (out_angle),
		.out_undef (out_undef)
	);

	// result word packing
	assign m_tdata    = OUT_DATA_W'(out_angle);
	assign m_tuser[0] = out_undef;

endmodule
